/* rtl/core/prc_pkg.sv */
package prc_pkg;

    // field widths
    localparam int TEMP_W      = 16;
    localparam int MS_W        = 16;
    localparam int GAIN_W      = 16;
    localparam int WIN_W       = 15;
    localparam int THR_W       = 31;
    localparam int ERR_W       = 17;
    localparam int DIFF_W      = 18;
    localparam int PROD_W      = 35;
    localparam int SUM_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // derivative divide: |kd * diff * 1000| < 2**43
    localparam int DIV_NUM_W   = 44;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_ITERS   = DIV_NUM_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

    // register reset values
    localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 16'sd1600;
    localparam logic [GAIN_W-1:0]        KP_RST       = 16'd3072;
    localparam logic [GAIN_W-1:0]        KI_RST       = 16'd51;
    localparam logic [GAIN_W-1:0]        KD_RST       = 16'd896;
    localparam logic [WIN_W-1:0]         WIN_RST      = 15'd800;
    localparam logic [THR_W-1:0]         THR_RST      = 31'd520192;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SCALE,
        S_DIV,
        S_SUM
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/core/pid_relay_controller_unit.sv */
// Windowed PID temperature controller with relay output.
// Input stream (s_axis): one word per sample, tdata = measured temperature (signed
// Q.4) and milliseconds since the previous sample. Output stream (m_axis): one word
// per sample, tdata = relay bit and saturated P+I+D drive sum (signed Q.12).
// Gains, setpoint, integration window and relay threshold sit on a simple write
// port (i_cfg_we/i_cfg_idx/i_cfg_data); write them only while no sample is in work.
// A single 17x18 multiplier is reused for the P, I and D products, then a
// two-bit-per-cycle restoring divider forms the derivative rate term.
// When elapsed_ms is nonzero the divide runs between the scale and sum steps; when
// elapsed_ms is zero the divide is skipped and the derivative term is zero. One
// sample is in work at a time, so a new word is not accepted until the sequencer
// has finished the last one.
// s_axis_tready is high only when the sequencer is idle. The result is held in an
// output register; the sequencer can take the next sample while it waits, but does
// not overwrite it until the receiver takes it, so a stalled receiver stalls input.
// Synchronous reset returns the configuration registers to their defaults and
// clears the integral, the stored error and the output valid.
module pid_relay_controller_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] measured_temp, [31:16] elapsed_ms
    input  logic [prc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] relay_on, [32:1] drive_sum, [39:33] zero
    output logic [prc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [prc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import prc_pkg::*;

    function automatic logic signed [SUM_W-1:0] sat32(input logic signed [45:0] v);
        logic signed [SUM_W-1:0] res;
        if (v[45:SUM_W-1] == '0 || v[45:SUM_W-1] == '1) begin
            res = v[SUM_W-1:0];
        end else if (v[45]) begin
            res = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(SUM_W-1){1'b1}}};
        end
        return res;
    endfunction

    // configuration
    logic signed [TEMP_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [GAIN_W-1:0]        r_kd;
    logic [WIN_W-1:0]         r_win;
    logic [THR_W-1:0]         r_thr;

    // sequencer and datapath
    t_state                   r_state;
    t_state                   n_state;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic [MS_W-1:0]          r_ms;
    logic signed [33:0]       r_p;
    logic signed [SUM_W-1:0]  r_accum;
    logic signed [ERR_W-1:0]  r_last;
    logic                     r_neg;
    logic signed [DIV_NUM_W:0] r_d;
    logic                     r_out_valid;
    logic [SUM_W-1:0]         r_out_sum;
    logic                     r_out_relay;

    logic                     in_acc;
    logic                     out_free;
    logic                     mul_en;
    logic [GAIN_W-1:0]        mul_gain;
    logic signed [DIFF_W-1:0] mul_val;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_NUM_W-1:0]     div_quot;
    t_div_stat                div_stat;

    logic signed [ERR_W-1:0]  in_err;
    logic signed [TEMP_W-1:0] in_meas;
    logic signed [DIV_NUM_W:0] prod_x;
    logic signed [DIV_NUM_W:0] scaled;
    logic signed [DIV_NUM_W:0] scaled_neg;
    logic signed [DIV_NUM_W:0] quot_s;
    logic signed [DIFF_W-1:0] win_s;
    logic                     in_window;
    logic signed [45:0]       accum_sum;
    logic signed [45:0]       drive_raw;
    logic signed [SUM_W-1:0]  drive_sat;
    logic                     relay;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign in_meas = $signed(s_axis_tdata[TEMP_W-1:0]);
    assign in_err  = ERR_W'(r_setpoint) - ERR_W'(in_meas);

    // x * 1000 = x*1024 - x*16 - x*8
    assign prod_x     = (DIV_NUM_W+1)'(prod);
    assign scaled     = (prod_x <<< 10) - (prod_x <<< 4) - (prod_x <<< 3);
    assign scaled_neg = -scaled;
    assign div_num    = scaled[DIV_NUM_W] ? scaled_neg[DIV_NUM_W-1:0] : scaled[DIV_NUM_W-1:0];
    assign quot_s     = $signed({1'b0, div_quot});

    assign win_s     = $signed({{(DIFF_W-WIN_W){1'b0}}, r_win});
    assign in_window = (DIFF_W'(r_err) > -win_s) && (DIFF_W'(r_err) < win_s);
    assign accum_sum = 46'(r_accum) + 46'($signed(prod[33:0]));
    assign drive_raw = 46'(r_p) + 46'(r_accum) + 46'(r_d);
    assign drive_sat = sat32(drive_raw);
    assign relay     = (33'(drive_sat) > $signed({2'b00, r_thr}));

    prc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_gain (mul_gain),
        .i_val  (mul_val),
        .o_prod (prod)
    );

    prc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_ms),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SETPOINT_RST;
            r_kp       <= KP_RST;
            r_ki       <= KI_RST;
            r_kd       <= KD_RST;
            r_win      <= WIN_RST;
            r_thr      <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETPOINT: r_setpoint <= $signed(i_cfg_data[TEMP_W-1:0]);
                CFG_KP:       r_kp       <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:       r_ki       <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:       r_kd       <= i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW:   r_win      <= i_cfg_data[WIN_W-1:0];
                CFG_THRESH:   r_thr      <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_en    = 1'b0;
        mul_gain  = r_kp;
        mul_val   = DIFF_W'(r_err);
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_MUL_P;
            end
            S_MUL_P: begin
                mul_en  = 1'b1;
                n_state = S_MUL_I;
            end
            S_MUL_I: begin
                mul_en   = 1'b1;
                mul_gain = r_ki;
                n_state  = S_MUL_D;
            end
            S_MUL_D: begin
                mul_en   = 1'b1;
                mul_gain = r_kd;
                mul_val  = r_diff;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                if (r_ms != '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_DIV: begin
                if (div_stat.done) n_state = S_SUM;
            end
            S_SUM: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state that survives between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_last  <= '0;
        end else if (r_state == S_MUL_D) begin
            r_accum <= in_window ? sat32(accum_sum) : '0;
            r_last  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err  <= in_err;
            r_diff <= DIFF_W'(in_err) - DIFF_W'(r_last);
            r_ms   <= s_axis_tdata[TEMP_W +: MS_W];
        end
        if (r_state == S_MUL_I) begin
            r_p <= prod[33:0];
        end
        if (r_state == S_SCALE) begin
            r_neg <= scaled[DIV_NUM_W];
            if (r_ms == '0) r_d <= '0;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_d <= r_neg ? -quot_s : quot_s;
        end
        if (r_state == S_SUM && out_free) begin
            r_out_sum   <= drive_sat;
            r_out_relay <= relay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_SUM && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-SUM_W-1){1'b0}}, r_out_sum, r_out_relay};

endmodule

/* rtl/core/prc_mul.sv */
module prc_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [prc_pkg::GAIN_W-1:0]            i_gain,
    input  logic signed [prc_pkg::DIFF_W-1:0]     i_val,
    output logic signed [prc_pkg::PROD_W-1:0]     o_prod
);
    import prc_pkg::*;

    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign gain_s = $signed({1'b0, i_gain});
    assign n_prod = gain_s * i_val;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/prc_divider.sv */
module prc_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [prc_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [prc_pkg::MS_W-1:0]        i_den,
    output logic [prc_pkg::DIV_NUM_W-1:0]   o_quot,
    output prc_pkg::t_div_stat              o_stat
);
    import prc_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] n_num;
    logic [MS_W-1:0]      r_rem;
    logic [MS_W-1:0]      n_rem;
    logic [MS_W-1:0]      r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // restoring divide, DIV_STEPS quotient bits per cycle; quotient shifts into r_num
    always_comb begin
        logic [MS_W:0]        trial;
        logic [MS_W-1:0]      rem;
        logic [DIV_NUM_W-1:0] num;
        rem = r_rem;
        num = r_num;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {rem, num[DIV_NUM_W-1]};
            num   = {num[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial  = trial - {1'b0, r_den};
                num[0] = 1'b1;
            end
            rem = trial[MS_W-1:0];
        end
        n_num = num;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= DIV_CNT_W'(DIV_ITERS - 1);
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot      = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* rtl/core/prc_checker.sv */
module prc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [prc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import prc_pkg::*;

    // one sample in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is in work");

    // threshold is never negative, so a non-positive sum keeps the relay off
    a_relay_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[SUM_W] || m_axis_tdata[SUM_W:1] == '0))
        |-> !m_axis_tdata[0])
        else $error("relay on with non-positive drive sum");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:SUM_W+1] == '0))
        else $error("output padding not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind pid_relay_controller_unit prc_checker u_prc_checker (.*);

/* verif/pid_relay_controller_unit_test.sv */
module pid_relay_controller_unit_test;
    import prc_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_SAMPLES  = 183;
    localparam longint MS_PER_SEC = 1000;
    localparam longint Q12_MAX    = 64'sd2147483647;
    localparam longint Q12_MIN    = -64'sd2147483648;
    // indexes past the register file, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [MS_W-1:0]          ms;
    } t_sample;

    typedef struct {
        logic                    relay;
        logic signed [SUM_W-1:0] sum;
    } t_drive;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [15:0] measured_temp, [31:16] elapsed_ms
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [0] relay_on, [32:1] drive_sum, [39:33] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    // controller copy: settings and loop state
    logic signed [TEMP_W-1:0] sp_reg;
    logic [GAIN_W-1:0]        kp_reg;
    logic [GAIN_W-1:0]        ki_reg;
    logic [GAIN_W-1:0]        kd_reg;
    logic [WIN_W-1:0]         win_reg;
    logic [THR_W-1:0]         thr_reg;
    longint                   integ_q12;
    longint                   prev_err;

    t_sample samples_to_send[$];
    t_drive  drive_expected[$];
    t_sample cur_sample;

    int samples_sent   = 0;
    int drives_checked = 0;
    int relay_ons      = 0;
    int mismatches     = 0;
    int settings_used  = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    bit no_idle        = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    pid_relay_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic longint clamp_q12(longint v);
        if (v > Q12_MAX) return Q12_MAX;
        if (v < Q12_MIN) return Q12_MIN;
        return v;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SETPOINT: sp_reg = val[TEMP_W-1:0];
            CFG_KP:       kp_reg = val[GAIN_W-1:0];
            CFG_KI:       ki_reg = val[GAIN_W-1:0];
            CFG_KD:       kd_reg = val[GAIN_W-1:0];
            CFG_WINDOW:   win_reg = val[WIN_W-1:0];
            CFG_THRESH:   thr_reg = val[THR_W-1:0];
            default: ;
        endcase
    endfunction

    // one control step: P + windowed I + rate-scaled D, all Q.12
    function automatic t_drive predict_drive(t_sample smp);
        longint err, win, p_q12, d_q12, total;
        t_drive res;
        err   = longint'(sp_reg) - longint'(smp.temp);
        win   = longint'(win_reg);
        p_q12 = longint'(kp_reg) * err;
        if (err > -win && err < win)
            integ_q12 = clamp_q12(integ_q12 + longint'(ki_reg) * err);
        else
            integ_q12 = 0;
        if (smp.ms == 0)
            d_q12 = 0;
        else
            d_q12 = (longint'(kd_reg) * (err - prev_err) * MS_PER_SEC) / longint'(smp.ms);
        prev_err  = err;
        total     = clamp_q12(p_q12 + integ_q12 + d_q12);
        res.relay = (total > longint'(thr_reg));
        res.sum   = total[SUM_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : sample_driver
        logic    vld;
        t_sample nxt;
        vld = s_axis_tvalid;
        if (!i_rst_n) begin
            vld = 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drive_expected.push_back(predict_drive(cur_sample));
                samples_sent++;
                vld = 1'b0;
                gap_left = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (!vld) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (samples_to_send.size() != 0) begin
                    nxt = samples_to_send.pop_front();
                    cur_sample = nxt;
                    s_axis_tdata <= {nxt.ms, nxt.temp};
                    vld = 1'b1;
                end
            end
        end
        s_axis_tvalid <= vld;
    end

    always @(posedge i_clk) begin : drive_monitor
        t_drive                  want;
        logic                    got_relay;
        logic signed [SUM_W-1:0] got_sum;
        logic                    rdy;
        if (!i_rst_n) begin
            rdy = 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_relay = m_axis_tdata[0];
                got_sum   = m_axis_tdata[SUM_W:1];
                if (drive_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual relay %0b sum %0d",
                             $time, got_relay, got_sum);
                end else begin
                    want = drive_expected.pop_front();
                    drives_checked++;
                    if (want.relay)
                        relay_ons++;
                    if (got_relay !== want.relay) begin
                        mismatches++;
                        $display("%0t: relay_on expected %0b actual %0b",
                                 $time, want.relay, got_relay);
                    end
                    if (got_sum !== want.sum) begin
                        mismatches++;
                        $display("%0t: drive_sum expected %0d actual %0d",
                                 $time, want.sum, got_sum);
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:SUM_W+1] !== '0) begin
                        mismatches++;
                        $display("%0t: tdata pad expected 0 actual %h",
                                 $time, m_axis_tdata[OUT_TDATA_W-1:SUM_W+1]);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("pid_relay_controller_unit test failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        apply_reg(idx, val);
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic add_sample(int temp, int ms);
        t_sample smp;
        smp.temp = temp[TEMP_W-1:0];
        smp.ms   = ms[MS_W-1:0];
        samples_to_send.push_back(smp);
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_axis_tvalid || drive_expected.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return GAIN_W'($urandom_range(0, 4095));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic random_settings();
        logic [CFG_DATA_W-1:0] junk;
        logic [TEMP_W-1:0]     sp;
        logic [WIN_W-1:0]      win;
        logic [THR_W-1:0]      thr;
        junk = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 4))
            0: sp = 16'h8000;
            1: sp = 16'h7FFF;
            2, 3: sp = TEMP_W'($urandom_range(0, 8000));
            default: sp = TEMP_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: win = '0;
            1: win = '1;
            2, 3: win = WIN_W'($urandom_range(1, 2000));
            default: win = WIN_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: thr = '0;
            1: thr = '1;
            2, 3: thr = THR_W'($urandom_range(0, 1 << 24));
            default: thr = THR_W'($urandom);
        endcase
        cfg_write(CFG_SETPOINT, {junk[CFG_DATA_W-1:TEMP_W], sp});
        cfg_write(CFG_KP, {junk[CFG_DATA_W-1:GAIN_W], pick_gain()});
        if ($urandom_range(0, 2) == 0)
            cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        cfg_write(CFG_KI, {~junk[CFG_DATA_W-1:GAIN_W], pick_gain()});
        cfg_write(CFG_KD, {junk[CFG_DATA_W-1:GAIN_W], pick_gain()});
        cfg_write(CFG_WINDOW, {junk[CFG_DATA_W-1:WIN_W], win});
        cfg_write(CFG_THRESH, thr);
        cfg_close();
    endtask

    // mostly errors around the window so the integral builds up, some edges, some noise
    task automatic queue_random_samples(int n);
        int      w, t, off;
        t_sample smp;
        w = int'(win_reg);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: t = int'($signed(16'($urandom)));
                2: begin
                    off = ($urandom_range(0, 1) != 0) ? w : -w;
                    t = int'(sp_reg) - off;
                end
                default: begin
                    off = int'($urandom_range(0, 2 * w)) - w;
                    t = int'(sp_reg) - off;
                end
            endcase
            if (t > 32767)
                t = 32767;
            else if (t < -32768)
                t = -32768;
            smp.temp = t[TEMP_W-1:0];
            case ($urandom_range(0, 7))
                0: smp.ms = '0;
                1: smp.ms = MS_W'($urandom);
                default: smp.ms = MS_W'($urandom_range(1, 2000));
            endcase
            samples_to_send.push_back(smp);
        end
    endtask

    initial begin
        sp_reg    = SETPOINT_RST;
        kp_reg    = KP_RST;
        ki_reg    = KI_RST;
        kd_reg    = KD_RST;
        win_reg   = WIN_RST;
        thr_reg   = THR_RST;
        integ_q12 = 0;
        prev_err  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        settings_used++;

        // reset settings: zero error, window edges both ways, zero and full elapsed time
        add_sample(1600, 1000);
        add_sample(800, 1000);
        add_sample(801, 500);
        add_sample(2399, 250);
        add_sample(2400, 0);
        add_sample(-32768, 1);
        add_sample(32767, 65535);
        add_sample(0, 0);
        add_sample(1599, 1);
        add_sample(1500, 300);
        add_sample(1500, 300);
        add_sample(1601, 65535);
        wait_drained();

        // full gains, widest window: P and D saturate, integral overflows
        cfg_write(CFG_SETPOINT, 31'h7FFF_8000);
        cfg_write(CFG_KP, '1);
        cfg_write(CFG_KI, '1);
        cfg_write(CFG_KD, '1);
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_WINDOW, '1);
        cfg_write(CFG_THRESH, '0);
        cfg_write(CFG_SPARE_HI, '1);
        cfg_close();
        add_sample(32767, 1);
        add_sample(-768, 0);
        add_sample(-768, 0);
        add_sample(-768, 0);
        add_sample(-1, 10);
        add_sample(-32768, 65535);
        wait_drained();

        // zero window always clears; tiny kd shows truncation toward zero
        cfg_write(CFG_SETPOINT, 31'h0000_7FFF);
        cfg_write(CFG_KP, '0);
        cfg_write(CFG_KI, '1);
        cfg_write(CFG_KD, 31'd1);
        cfg_write(CFG_WINDOW, '0);
        cfg_write(CFG_THRESH, '1);
        cfg_close();
        add_sample(32767, 5);
        add_sample(-32768, 7);
        add_sample(32767, 7);
        add_sample(0, 3);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            no_idle = (ph % 4 == 1);
            random_settings();
            queue_random_samples(PHASE_SAMPLES);
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (drive_expected.size() != 0) begin
            mismatches++;
            $display("%0t: drive words expected %0d more, actual none",
                     $time, drive_expected.size());
        end
        $display("Checked %0d drive words for %0d samples across %0d register settings;",
                 drives_checked, samples_sent, settings_used);
        $display("relay on in %0d, window edges, zero elapsed, saturation, dropped indexes.",
                 relay_ons);
        if (mismatches == 0)
            $display("pid_relay_controller_unit test passed");
        else
            $display("pid_relay_controller_unit test failed");
        $finish;
    end

endmodule
